/* design/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("port check failed");

// Same check, but also evaluated while reset is high.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("port check failed");

`endif

/* design/daept_pkg.sv */
// Types and constants of the dual axis encoder period tracker.
package daept_pkg;

   localparam int ID_BITS         = 11;
   localparam int DATA_BITS       = 16;
   localparam int REQ_TDATA_BITS  = 32;

   localparam logic [ID_BITS-1:0] AZ_ID_RESET = 11'h021;
   localparam logic [ID_BITS-1:0] EL_ID_RESET = 11'h041;

   // Word kinds on the request side.
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_FRAME = 1'b1;

   // Axis codes on the response side.
   localparam logic AXIS_AZ = 1'b0;
   localparam logic AXIS_EL = 1'b1;

   // Register indexes of the configuration port.
   localparam logic REG_AZ_ID = 1'b0;
   localparam logic REG_EL_ID = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

/* design/dual_axis_encoder_period_tracker.sv */
// Top level: period measurement for two absolute angle encoders fed by CAN frames.
//
//   Channel | Ports  | Contents
//   --------+--------+---------------------------------------------------------
//   request | req_*  | tuser: kind (tick/frame); tdata: frame id, frame data
//   result  | rsp_*  | tuser: axis; tdata: angle, step, period, stalled, pin
//   config  | csr_*  | write enable, register index, 11-bit frame id
//
// A tick word bumps both saturating elapsed-time counters.
// A matching frame word first latches the angle and step, then goes through
// the shared restoring divider that forms one quotient bit per cycle, and
// finally loads the result register.
// A zero step skips the divider. A frame that matches no register is
// consumed and leaves no trace.
// Reset is synchronous and clears the counters, last angles, pin and the ids
// to their defaults. req_tready is low only while a frame is in the divider or
// waiting for the result register; a finished word in the result register does
// not block ticks or a new frame from being taken.
module dual_axis_encoder_period_tracker #(
   parameter int ANGLE_BITS = 14,
   parameter int TIMER_BITS = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic                                req_tuser,  // [0] cmd
   input  logic [daept_pkg::REQ_TDATA_BITS-1:0] req_tdata, // [10:0] frame_id,
                                                           // [26:11] frame_data
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tuser,  // [0] axis
   // angle, step, period, stalled, pin_level from the lowest bit up
   output logic [((2*ANGLE_BITS+TIMER_BITS+2+7)/8)*8-1:0] rsp_tdata,
   // configuration port
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [daept_pkg::ID_BITS-1:0]       csr_wdata
);

   localparam int RSP_BITS       = 2*ANGLE_BITS + TIMER_BITS + 2;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;
   localparam int CNT_BITS       = (TIMER_BITS > 1) ? $clog2(TIMER_BITS) : 1;
   localparam int EXT_BITS       = ANGLE_BITS + daept_pkg::DATA_BITS;

   // Request fields.
   logic                             req_cmd;
   logic [daept_pkg::ID_BITS-1:0]    req_frame_id;
   logic [daept_pkg::DATA_BITS-1:0]  req_frame_data;
   logic [EXT_BITS-1:0]              data_ext;
   logic [ANGLE_BITS-1:0]            new_angle;

   assign req_cmd        = req_tuser;
   assign req_frame_id   = req_tdata[daept_pkg::ID_BITS-1:0];
   assign req_frame_data = req_tdata[daept_pkg::ID_BITS +: daept_pkg::DATA_BITS];
   assign data_ext       = EXT_BITS'(req_frame_data);
   assign new_angle      = data_ext[ANGLE_BITS-1:0];

   // Control state.
   daept_pkg::state_type state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Architectural state.
   logic [daept_pkg::ID_BITS-1:0] az_id_ff, az_id_in;
   logic [daept_pkg::ID_BITS-1:0] el_id_ff, el_id_in;
   logic [ANGLE_BITS-1:0]         last_az_ff, last_az_in;
   logic [ANGLE_BITS-1:0]         last_el_ff, last_el_in;
   logic [TIMER_BITS-1:0]         az_ticks_ff, az_ticks_in;
   logic [TIMER_BITS-1:0]         el_ticks_ff, el_ticks_in;
   logic                          pin_ff, pin_in;

   // Working payload of the frame in flight.
   logic                  axis_ff, axis_in;
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [ANGLE_BITS-1:0] step_ff, step_in;
   logic                  stall_ff, stall_in;
   logic [ANGLE_BITS-1:0] rem_ff, rem_in;
   logic [TIMER_BITS-1:0] quo_ff, quo_in;

   // Result register payload.
   logic                rsp_axis_ff, rsp_axis_in;
   logic [RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Decode of the word offered on the request side.
   logic                  req_fire;
   logic                  hit_az;
   logic                  hit_el;
   logic                  frame_hit;
   logic [ANGLE_BITS-1:0] sel_last;
   logic [ANGLE_BITS-1:0] new_step;
   logic                  last_div;
   logic                  emit_load;

   // Shared divider step: shift in the next dividend bit, try to subtract.
   logic [ANGLE_BITS:0]   trial;
   logic [ANGLE_BITS:0]   divisor_ext;
   logic [ANGLE_BITS:0]   diff;
   logic                  fits;

   assign req_fire  = req_tvalid && req_tready;
   assign hit_az    = (req_cmd == daept_pkg::CMD_FRAME) && (req_frame_id == az_id_ff);
   assign hit_el    = (req_cmd == daept_pkg::CMD_FRAME) && (req_frame_id == el_id_ff)
                      && !hit_az;
   assign frame_hit = hit_az || hit_el;
   assign sel_last  = hit_az ? last_az_ff : last_el_ff;
   assign new_step  = new_angle - sel_last;
   assign last_div  = (cnt_ff == '0);

   assign trial       = {rem_ff, quo_ff[TIMER_BITS-1]};
   assign divisor_ext = {1'b0, step_ff};
   assign fits        = (trial >= divisor_ext);
   assign diff        = trial - divisor_ext;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         daept_pkg::ST_IDLE: begin
            if (req_fire && frame_hit) begin
               state_in = (new_step == '0) ? daept_pkg::ST_EMIT : daept_pkg::ST_DIVIDE;
            end
         end
         daept_pkg::ST_DIVIDE: begin
            if (last_div) begin
               state_in = daept_pkg::ST_EMIT;
            end
         end
         daept_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = daept_pkg::ST_IDLE;
            end
         end
         default: state_in = daept_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      emit_load  = 1'b0;
      unique case (state_ff)
         daept_pkg::ST_IDLE:   req_tready = 1'b1;
         daept_pkg::ST_DIVIDE: req_tready = 1'b0;
         daept_pkg::ST_EMIT:   emit_load  = !rsp_valid_ff || rsp_tready;
         default:              req_tready = 1'b0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      az_id_in    = az_id_ff;
      el_id_in    = el_id_ff;
      last_az_in  = last_az_ff;
      last_el_in  = last_el_ff;
      az_ticks_in = az_ticks_ff;
      el_ticks_in = el_ticks_ff;
      pin_in      = pin_ff;
      axis_in     = axis_ff;
      angle_in    = angle_ff;
      step_in     = step_ff;
      stall_in    = stall_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      rsp_axis_in = rsp_axis_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            daept_pkg::REG_AZ_ID: az_id_in = csr_wdata;
            daept_pkg::REG_EL_ID: el_id_in = csr_wdata;
            default:              az_id_in = az_id_ff;
         endcase
      end

      if (req_fire && (req_cmd == daept_pkg::CMD_TICK)) begin
         // Saturating elapsed-time counters.
         if (!(&az_ticks_ff)) begin
            az_ticks_in = az_ticks_ff + TIMER_BITS'(1);
         end
         if (!(&el_ticks_ff)) begin
            el_ticks_in = el_ticks_ff + TIMER_BITS'(1);
         end
      end

      if (req_fire && frame_hit) begin
         axis_in  = hit_az ? daept_pkg::AXIS_AZ : daept_pkg::AXIS_EL;
         angle_in = new_angle;
         step_in  = new_step;
         stall_in = (new_step == '0);
         rem_in   = '0;
         cnt_in   = CNT_BITS'(TIMER_BITS - 1);
         if (new_step == '0) begin
            quo_in = '1;
         end else begin
            quo_in = hit_az ? az_ticks_ff : el_ticks_ff;
         end
         if (hit_az) begin
            last_az_in  = new_angle;
            az_ticks_in = '0;
         end else begin
            last_el_in  = new_angle;
            el_ticks_in = '0;
            pin_in      = !pin_ff;
         end
      end

      if (state_ff == daept_pkg::ST_DIVIDE) begin
         rem_in = fits ? diff[ANGLE_BITS-1:0] : trial[ANGLE_BITS-1:0];
         quo_in = {quo_ff[TIMER_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_BITS'(1);
      end

      if (emit_load) begin
         rsp_axis_in = axis_ff;
         rsp_data_in = {pin_ff, stall_ff, quo_ff, step_ff, angle_ff};
      end
   end

   // The result register is full from a load until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= daept_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         az_id_ff     <= daept_pkg::AZ_ID_RESET;
         el_id_ff     <= daept_pkg::EL_ID_RESET;
         last_az_ff   <= '0;
         last_el_ff   <= '0;
         az_ticks_ff  <= '0;
         el_ticks_ff  <= '0;
         pin_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         az_id_ff     <= az_id_in;
         el_id_ff     <= el_id_in;
         last_az_ff   <= last_az_in;
         last_el_ff   <= last_el_in;
         az_ticks_ff  <= az_ticks_in;
         el_ticks_ff  <= el_ticks_in;
         pin_ff       <= pin_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff     <= axis_in;
      angle_ff    <= angle_in;
      step_ff     <= step_in;
      stall_ff    <= stall_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_axis_ff;
   assign rsp_tdata  = RSP_TDATA_BITS'(rsp_data_ff);

endmodule

/* design/daept_checker.sv */
// Port-level checks of the period tracker, bound to the top level.
`include "assert_macros.svh"

module daept_checker #(
   parameter int ANGLE_BITS = 14,
   parameter int TIMER_BITS = 31
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic                                rsp_tuser,
   input logic [((2*ANGLE_BITS+TIMER_BITS+2+7)/8)*8-1:0] rsp_tdata
);

   localparam int STEP_LSB   = ANGLE_BITS;
   localparam int PERIOD_LSB = 2*ANGLE_BITS;
   localparam int STALL_BIT  = 2*ANGLE_BITS + TIMER_BITS;

   logic [ANGLE_BITS-1:0] step_f;
   logic [TIMER_BITS-1:0] period_f;
   logic                  stall_f;
   logic                  tick_fire;

   assign step_f    = rsp_tdata[STEP_LSB +: ANGLE_BITS];
   assign period_f  = rsp_tdata[PERIOD_LSB +: TIMER_BITS];
   assign stall_f   = rsp_tdata[STALL_BIT];
   assign tick_fire = req_tvalid && req_tready && (req_tuser == daept_pkg::CMD_TICK);

   // A result held back by the consumer keeps its contents.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // The stall flag goes with a zero step and a saturated period.
   `CHK_ASSERT(a_stall_sat, clock, reset, rsp_tvalid && stall_f |-> (step_f == '0) && (&period_f))

   // A nonzero step never reports a stall.
   `CHK_ASSERT(a_step_nostall, clock, reset, rsp_tvalid && (step_f != '0) |-> !stall_f)

   // A tick finishes in its own cycle, so the input stays open after it.
   `CHK_ASSERT(a_tick_single, clock, reset, tick_fire |=> req_tready)

   // No result is offered in the cycle after reset.
   `CHK_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind dual_axis_encoder_period_tracker daept_checker #(
   .ANGLE_BITS(ANGLE_BITS),
   .TIMER_BITS(TIMER_BITS)
) u_daept_checker (.*);

/* dv/tb_dual_axis_encoder_period_tracker.sv */
// Self-checking testbench for the dual axis encoder period tracker.
module tb_dual_axis_encoder_period_tracker;

   // The block's default geometry; the response word is 64 bits wide.
   localparam int ANGLE_W = 14;
   localparam int TIMER_W = 31;
   localparam int RSP_W = ((2*ANGLE_W+TIMER_W+2+7)/8)*8;
   localparam int ID_W = daept_pkg::ID_BITS;
   localparam int DATA_W = daept_pkg::DATA_BITS;
   localparam int REQ_W = daept_pkg::REQ_TDATA_BITS;

   // The drain margin covers one frame in flight plus a stall-free handoff
   // to the result register.
   localparam int DRAIN_CYCLES = TIMER_W + 9;

   // The slowest correct run is about 1800 words, each paying a full divide,
   // the longest sender gap and the longest receiver stall. The limit below
   // leaves a wide margin over that.
   localparam int unsigned LIMIT_CYCLES = 600000;

   // One request word as the generator and the predictor see it.
   typedef struct packed {
      logic              kind;
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] data;
   } can_word_type;

   // One expected axis update, in the field order of the result channel.
   typedef struct packed {
      logic               axis;
      logic [ANGLE_W-1:0] angle;
      logic [ANGLE_W-1:0] step;
      logic [TIMER_W-1:0] period;
      logic               stalled;
      logic               pin;
   } axis_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic             req_tuser = daept_pkg::CMD_TICK;
   logic [REQ_W-1:0] req_tdata = '0;

   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             rsp_tuser;
   logic [RSP_W-1:0] rsp_tdata;

   logic            csr_we = 1'b0;
   logic            csr_index = daept_pkg::REG_AZ_ID;
   logic [ID_W-1:0] csr_wdata = '0;

   dual_axis_encoder_period_tracker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Words waiting for the driver, and axis updates waiting for the monitor.
   can_word_type    pending_words[$];
   axis_update_type pending_updates[$];

   // Shadow of the block's state. The frame ids are written only while the
   // block is idle, so the generator may read them as well.
   logic [ID_W-1:0]    az_id = daept_pkg::AZ_ID_RESET;
   logic [ID_W-1:0]    el_id = daept_pkg::EL_ID_RESET;
   logic [ANGLE_W-1:0] az_last = '0;
   logic [ANGLE_W-1:0] el_last = '0;
   logic [TIMER_W-1:0] az_ticks = '0;
   logic [TIMER_W-1:0] el_ticks = '0;
   logic               pin_state = 1'b0;

   // The generator runs ahead of the block, so it keeps its own idea of the
   // last angle per axis to aim steps at zero or at small values.
   logic [ANGLE_W-1:0] gen_az_last = '0;
   logic [ANGLE_W-1:0] gen_el_last = '0;

   // Idling controls, in percent chance of a burst after each word or cycle.
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   int           words_queued = 0;
   int           words_taken = 0;
   int           ticks_taken = 0;
   int           frames_taken = 0;
   int           frames_ignored = 0;
   int           results_checked = 0;
   int           stalls_checked = 0;
   int           mismatches = 0;
   int unsigned  cycle_count = 0;
   can_word_type req_word;

   // Expected outcome of one matching frame on the axis whose last angle and
   // elapsed time are given. The period is ticks per count of angle.
   function automatic axis_update_type measure_axis(input logic axis,
                                                    input logic [DATA_W-1:0] data,
                                                    input logic [ANGLE_W-1:0] last,
                                                    input logic [TIMER_W-1:0] ticks,
                                                    input logic pin);
      axis_update_type u;
      u.axis = axis;
      u.angle = data[ANGLE_W-1:0];
      u.step = u.angle - last;
      u.stalled = (u.step == '0);
      u.period = u.stalled ? '1 : ticks / {{(TIMER_W-ANGLE_W){1'b0}}, u.step};
      u.pin = pin;
      return u;
   endfunction

   // Applies one accepted word to the shadow state. The azimuth id wins when
   // both ids are equal, and a frame matching neither id is dropped.
   task automatic track_word(input can_word_type w);
      axis_update_type u;
      words_taken++;
      if (w.kind == daept_pkg::CMD_TICK) begin
         ticks_taken++;
         if (az_ticks != '1) az_ticks = az_ticks + 1'b1;
         if (el_ticks != '1) el_ticks = el_ticks + 1'b1;
      end else begin
         frames_taken++;
         if (w.id == az_id) begin
            u = measure_axis(daept_pkg::AXIS_AZ, w.data, az_last, az_ticks, pin_state);
            az_last = u.angle;
            az_ticks = '0;
            pending_updates.push_back(u);
         end else if (w.id == el_id) begin
            pin_state = ~pin_state;
            u = measure_axis(daept_pkg::AXIS_EL, w.data, el_last, el_ticks, pin_state);
            el_last = u.angle;
            el_ticks = '0;
            pending_updates.push_back(u);
         end else begin
            frames_ignored++;
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Request driver. A word stays on the bus until it is taken; after a word
   // is put on the bus a random gap may follow it.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) track_word(req_word);
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_word = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= req_word.kind;
               req_tdata <= {{(REQ_W-ID_W-DATA_W){1'b0}}, req_word.data, req_word.id};
               if ($urandom_range(0, 99) < req_idle_pct) req_gap = $urandom_range(1, 16);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every taken result word is compared with the oldest
   // expected update; stall bursts are drawn independently of rsp_tvalid so
   // that they also hit the cycles in which the divider is still running.
   always @(posedge clock) begin
      axis_update_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_updates.size() == 0) begin
               $error("result word with nothing expected: axis %0d, tdata %0h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_updates.pop_front();
               results_checked++;
               if (want.stalled) stalls_checked++;
               check_field("axis", want.axis, rsp_tuser);
               check_field("angle", want.angle, rsp_tdata[ANGLE_W-1:0]);
               check_field("step", want.step, rsp_tdata[2*ANGLE_W-1:ANGLE_W]);
               check_field("period", want.period,
                           rsp_tdata[2*ANGLE_W+TIMER_W-1:2*ANGLE_W]);
               check_field("stalled", want.stalled, rsp_tdata[2*ANGLE_W+TIMER_W]);
               check_field("pin_level", want.pin, rsp_tdata[2*ANGLE_W+TIMER_W+1]);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 99) < rsp_idle_pct) rsp_gap = $urandom_range(1, 16);
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Tick words carry random id and data bits, which the block must ignore.
   task automatic add_ticks(input int count);
      can_word_type w;
      repeat (count) begin
         w.kind = daept_pkg::CMD_TICK;
         w.id = ID_W'($urandom);
         w.data = DATA_W'($urandom);
         pending_words.push_back(w);
         words_queued++;
      end
   endtask

   task automatic add_frame(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] data);
      can_word_type w;
      w.kind = daept_pkg::CMD_FRAME;
      w.id = id;
      w.data = data;
      pending_words.push_back(w);
      words_queued++;
      if (id == az_id) gen_az_last = data[ANGLE_W-1:0];
      else if (id == el_id) gen_el_last = data[ANGLE_W-1:0];
   endtask

   // Random traffic: tick runs (mostly short, now and then long enough to
   // give large periods), frames for either axis aimed at zero, small forward,
   // small backward or random steps, and frames with ids that match nothing.
   task automatic add_random_words(input int count);
      int                 stop_at;
      int                 pick;
      logic               to_el;
      logic [ANGLE_W-1:0] ang;
      logic [1:0]         spare;
      logic [ID_W-1:0]    id;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 19) == 0) add_ticks($urandom_range(50, 300));
            else add_ticks($urandom_range(1, 10));
         end else if (pick < 85) begin
            to_el = 1'($urandom_range(0, 1));
            ang = to_el ? gen_el_last : gen_az_last;
            spare = 2'($urandom);
            pick = $urandom_range(0, 99);
            // A repeated angle is the stalled case.
            if (pick >= 55) ang = ANGLE_W'($urandom);
            else if (pick >= 40) ang = ang - ANGLE_W'($urandom_range(1, 4));
            else if (pick >= 10) ang = ang + ANGLE_W'($urandom_range(1, 4));
            add_frame(to_el ? el_id : az_id, {spare, ang});
         end else begin
            id = ID_W'($urandom);
            while (id == az_id || id == el_id) id = ID_W'($urandom);
            add_frame(id, DATA_W'($urandom));
         end
      end
   endtask

   // Waits until every queued word has been taken and every expected update
   // has come back, then lets the drain margin pass.
   task automatic wait_drained();
      do @(posedge clock);
      while (words_taken != words_queued || pending_updates.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_id(input logic index, input logic [ID_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == daept_pkg::REG_AZ_ID) az_id = value;
      else el_id = value;
   endtask

   initial begin
      logic [ID_W-1:0] shared_id;
      logic [ID_W-1:0] first_id;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the reset ids. Both axes start at angle zero, so
      // the first frame of each is a zero step. The elevation frame also has
      // the spare data bits set, which must be masked off.
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      add_frame(daept_pkg::AZ_ID_RESET, 16'h0000);
      add_frame(daept_pkg::EL_ID_RESET, 16'hC000);
      add_ticks(4);
      // Largest forward step, then smallest; the pin toggles back.
      add_frame(daept_pkg::AZ_ID_RESET, 16'hFFFF);
      add_frame(daept_pkg::EL_ID_RESET, 16'h0001);
      // Ids at the extremes and a near miss are all dropped.
      add_frame(11'h7FF, 16'hFFFF);
      add_frame(11'h000, 16'h1234);
      add_frame(daept_pkg::AZ_ID_RESET ^ 11'h001, 16'h5555);
      add_ticks(6);
      // Wrap from the top of the angle range to zero is a step of one.
      add_frame(daept_pkg::AZ_ID_RESET, 16'h0000);
      add_frame(daept_pkg::EL_ID_RESET, 16'h3FFF);
      add_frame(daept_pkg::AZ_ID_RESET, 16'h4005);
      add_frame(daept_pkg::EL_ID_RESET, 16'h2000);
      wait_drained();

      // Extreme ids on the two registers.
      write_frame_id(daept_pkg::REG_AZ_ID, 11'h000);
      write_frame_id(daept_pkg::REG_EL_ID, 11'h7FF);
      req_idle_pct = 40;
      rsp_idle_pct = 10;
      add_random_words(600);
      wait_drained();

      // Both registers equal: every matching frame is an azimuth frame.
      shared_id = ID_W'($urandom);
      write_frame_id(daept_pkg::REG_AZ_ID, shared_id);
      write_frame_id(daept_pkg::REG_EL_ID, shared_id);
      req_idle_pct = 10;
      rsp_idle_pct = 40;
      add_random_words(600);
      wait_drained();

      // Random distinct ids, the opposite extremes swapped in first.
      write_frame_id(daept_pkg::REG_AZ_ID, 11'h7FF);
      write_frame_id(daept_pkg::REG_EL_ID, 11'h000);
      first_id = ID_W'($urandom);
      write_frame_id(daept_pkg::REG_AZ_ID, first_id);
      write_frame_id(daept_pkg::REG_EL_ID, first_id ^ 11'($urandom_range(1, 2047)));
      req_idle_pct = 25;
      rsp_idle_pct = 25;
      add_random_words(400);
      do @(posedge clock);
      while (words_taken != words_queued);
      // The closing stretch runs with both sides always ready.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      req_gap = 0;
      rsp_gap = 0;
      add_random_words(200);
      wait_drained();

      $display("Covered %0d words: %0d ticks, %0d frames (%0d with unmatched ids).",
               words_taken, ticks_taken, frames_taken, frames_ignored);
      $display("Checked %0d axis updates, %0d of them stalled, over four id settings.",
               results_checked, stalls_checked);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/daept_pkg.sv
design/dual_axis_encoder_period_tracker.sv
design/daept_checker.sv
dv/tb_dual_axis_encoder_period_tracker.sv
